// ===== rtl/core/tpq_pkg.sv =====
// shared types, constants and register codes of the touch press qualifier
// no dependencies

package tpq_pkg;

   // default window length, the parameter range is 3 to 9
   localparam int WINDOW_SAMPLES = 5;

   localparam int COORD_W   = 12;
   localparam int TIME_W    = 32;
   localparam int GUARD_W   = 16;
   localparam int SPREAD_W  = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [TIME_W-1:0]         time_type;
   typedef logic [GUARD_W-1:0]        guard_type;
   typedef logic [SPREAD_W-1:0]       spread_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;
   typedef logic [CSR_DAT_W-1:0]      csr_dat_type;

   // register indexes
   localparam csr_idx_type CSR_RELEASE_GUARD = 2'd0;
   localparam csr_idx_type CSR_MAX_SPREAD    = 2'd1;

   localparam guard_type  GUARD_RESET  = 16'd70;
   localparam spread_type SPREAD_RESET = 12'd10;

   // per-cycle controls broadcast along the cell row
   typedef struct packed {
      logic shift;
      logic load;
      logic compare;
   } cell_ctl_type;

   // what the row hands back once all compare steps are done
   typedef struct packed {
      logic      wide;
      coord_type med_x;
      coord_type med_y;
   } chain_res_type;

endpackage

// ===== rtl/core/tpq_req_if.sv =====
// request channel: one touch poll per word
// depends on tpq_pkg

interface tpq_req_if;
   logic                valid;
   logic                ready;
   logic                touch_down;
   tpq_pkg::coord_type  pos_x;
   tpq_pkg::coord_type  pos_y;
   tpq_pkg::time_type   now_ms;

   modport source (output valid, touch_down, pos_x, pos_y, now_ms, input ready);
   modport sink   (input valid, touch_down, pos_x, pos_y, now_ms, output ready);
endinterface

// ===== rtl/core/tpq_rsp_if.sv =====
// response channel: one qualified press result per word
// depends on tpq_pkg

interface tpq_rsp_if;
   logic                valid;
   logic                ready;
   logic                press_valid;
   tpq_pkg::coord_type  press_x;
   tpq_pkg::coord_type  press_y;

   modport source (output valid, press_valid, press_x, press_y, input ready);
   modport sink   (input valid, press_valid, press_x, press_y, output ready);
endinterface

// ===== rtl/core/tpq_csr_if.sv =====
// configuration write channel: register index and write data per word
// depends on tpq_pkg

interface tpq_csr_if;
   logic                  valid;
   logic                  ready;
   tpq_pkg::csr_idx_type  index;
   tpq_pkg::csr_dat_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/touch_press_qualifier_unit.sv =====
// top level of the touch press qualifier: press tracking, window control, output register
// depends on tpq_pkg, tpq_req_if, tpq_rsp_if, tpq_csr_if and tpq_chain
//
//  channel  | dir | words                                   | accepted when
//  ---------+-----+-----------------------------------------+---------------------
//  req_ch   | in  | touch_down, pos_x, pos_y, now_ms        | valid && ready
//  rsp_ch   | out | press_valid, press_x, press_y           | valid && ready
//  csr_ch   | in  | index, data (0 release guard, 1 spread) | valid && ready
//
// every request word gives exactly one response word
// a word that completes the window passes through these steps in order:
//   accept, visitor load, WINDOW_SAMPLES - 1 ring compare steps, decision, hand-off
// any other word goes from accept straight to hand-off to the output register
// the ring of cells sets how long a completing word takes: one visitor hop per cycle
// a finished word waits in the output register while the next request is taken;
// hand-off stalls only when that register is still full
// reset (synchronous) clears the press tracking, the release time and the registers

module touch_press_qualifier_unit #(
   parameter int WINDOW_SAMPLES = tpq_pkg::WINDOW_SAMPLES
) (
   input logic        clock,
   input logic        reset,
   tpq_req_if.sink    req_ch,
   tpq_rsp_if.source  rsp_ch,
   tpq_csr_if.sink    csr_ch
);

   localparam int STEP_W = $clog2(WINDOW_SAMPLES);
   localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_SAMPLES);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WINDOW_SAMPLES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   tpq_pkg::guard_type  guard_ff;
   tpq_pkg::spread_type spread_ff;

   // press tracking
   logic               was_down_ff, was_down_in;
   logic               handled_ff, handled_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   tpq_pkg::time_type  release_ff, release_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // pending result and output register
   logic               pend_valid_ff, pend_valid_in;
   tpq_pkg::coord_type pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_valid_ff, out_valid_in;
   tpq_pkg::coord_type out_x_ff, out_x_in, out_y_ff, out_y_in;

   logic                  accept, collect, hnd_eff, guard_ok, out_free;
   logic [CNT_W-1:0]      cnt_eff, cnt_next;
   tpq_pkg::time_type     elapsed;
   tpq_pkg::cell_ctl_type ctl;
   tpq_pkg::chain_res_type res;

   // request side
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // a new press (down after up) starts from a clear count and handled flag
   assign hnd_eff  = was_down_ff & handled_ff;
   assign cnt_eff  = was_down_ff ? count_ff : '0;
   // wrapping elapsed time since the last release
   assign elapsed  = req_ch.now_ms - release_ff;
   assign guard_ok = elapsed > {{(tpq_pkg::TIME_W - tpq_pkg::GUARD_W){1'b0}}, guard_ff};
   assign collect  = req_ch.touch_down && !hnd_eff && guard_ok;
   assign cnt_next = cnt_eff + CNT_W'(cnt_eff < FULL_CNT);

   // controls for the cell ring
   assign ctl.shift   = accept && collect && (cnt_eff < FULL_CNT);
   assign ctl.load    = (state_ff == ST_EVAL) && (step_ff == '0);
   assign ctl.compare = (state_ff == ST_EVAL) && (step_ff != '0);

   tpq_chain #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .step       (step_ff),
      .max_spread (spread_ff),
      .sample_x   (req_ch.pos_x),
      .sample_y   (req_ch.pos_y),
      .res        (res)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      was_down_in   = was_down_ff;
      handled_in    = handled_ff;
      count_in      = count_ff;
      release_in    = release_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_valid_in  = out_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_valid_in = 1'b0;
               pend_x_in     = '0;
               pend_y_in     = '0;
               step_in       = '0;
               was_down_in   = req_ch.touch_down;
               state_in      = ST_FINISH;
               if (req_ch.touch_down) begin
                  handled_in = hnd_eff;
                  count_in   = collect ? cnt_next : cnt_eff;
                  // window just filled: run the ring
                  if (collect && (cnt_next == FULL_CNT)) state_in = ST_EVAL;
               end else begin
                  if (was_down_ff) release_in = req_ch.now_ms;
                  handled_in = 1'b0;
                  count_in   = '0;
               end
            end
         end
         ST_EVAL: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (res.wide) begin
               // unstable window: the newest sample already sits in cell zero
               count_in = CNT_W'(1);
            end else begin
               pend_valid_in = 1'b1;
               pend_x_in     = res.med_x;
               pend_y_in     = res.med_y;
               handled_in    = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_valid_in = pend_valid_ff;
               out_x_in     = pend_x_ff;
               out_y_in     = pend_y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, tracking and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         was_down_ff   <= 1'b0;
         handled_ff    <= 1'b0;
         count_ff      <= '0;
         release_ff    <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_x_ff     <= '0;
         pend_y_ff     <= '0;
         out_x_ff      <= '0;
         out_y_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         was_down_ff   <= was_down_in;
         handled_ff    <= handled_in;
         count_ff      <= count_in;
         release_ff    <= release_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         pend_x_ff     <= pend_x_in;
         pend_y_ff     <= pend_y_in;
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
      end
   end

   // configuration port, always ready; unknown indexes are dropped
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff  <= tpq_pkg::GUARD_RESET;
         spread_ff <= tpq_pkg::SPREAD_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            tpq_pkg::CSR_RELEASE_GUARD: guard_ff  <= csr_ch.data[tpq_pkg::GUARD_W-1:0];
            tpq_pkg::CSR_MAX_SPREAD:    spread_ff <= csr_ch.data[tpq_pkg::SPREAD_W-1:0];
            default: ;
         endcase
      end
   end

   // response side
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.press_valid = out_valid_ff;
   assign rsp_ch.press_x     = out_x_ff;
   assign rsp_ch.press_y     = out_y_ff;

endmodule

// ===== rtl/core/tpq_cell.sv =====
// one window cell: holds a sample, a circulating visitor, ranks and a spread flag
// depends on tpq_pkg

module tpq_cell #(
   parameter int WINDOW_SAMPLES = tpq_pkg::WINDOW_SAMPLES,
   parameter int CELL_INDEX     = 0,
   localparam int STEP_W        = $clog2(WINDOW_SAMPLES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tpq_pkg::cell_ctl_type ctl,
   input  logic [STEP_W-1:0]     step,
   input  tpq_pkg::spread_type   max_spread,
   input  tpq_pkg::coord_type    shift_x,
   input  tpq_pkg::coord_type    shift_y,
   input  tpq_pkg::coord_type    own_left_x,
   input  tpq_pkg::coord_type    own_left_y,
   input  tpq_pkg::coord_type    vis_left_x,
   input  tpq_pkg::coord_type    vis_left_y,
   output tpq_pkg::coord_type    own_x,
   output tpq_pkg::coord_type    own_y,
   output tpq_pkg::coord_type    vis_x,
   output tpq_pkg::coord_type    vis_y,
   output logic                  hit_x,
   output logic                  hit_y,
   output logic                  wide
);

   localparam logic [STEP_W-1:0] MID_RANK = STEP_W'(WINDOW_SAMPLES / 2);
   localparam logic [STEP_W-1:0] MY_INDEX = STEP_W'(CELL_INDEX);

   tpq_pkg::coord_type own_x_ff, own_y_ff, vis_x_ff, vis_y_ff;
   logic [STEP_W-1:0]  rank_x_ff, rank_y_ff, rank_x_in, rank_y_in;
   logic               wide_ff, wide_in;

   logic               less_x, less_y, earlier;
   logic signed [12:0] diff_x, diff_y;
   logic               far_x, far_y;

   // visitor came from a lower cell index when step <= own index
   assign earlier = (step <= MY_INDEX);
   assign less_x  = (vis_x_ff < own_x_ff) || ((vis_x_ff == own_x_ff) && earlier);
   assign less_y  = (vis_y_ff < own_y_ff) || ((vis_y_ff == own_y_ff) && earlier);

   assign diff_x = $signed({own_x_ff[11], own_x_ff}) - $signed({vis_x_ff[11], vis_x_ff});
   assign diff_y = $signed({own_y_ff[11], own_y_ff}) - $signed({vis_y_ff[11], vis_y_ff});
   assign far_x  = $signed({diff_x[12], diff_x}) > $signed({2'b00, max_spread});
   assign far_y  = $signed({diff_y[12], diff_y}) > $signed({2'b00, max_spread});

   always_comb begin
      rank_x_in = rank_x_ff;
      rank_y_in = rank_y_ff;
      wide_in   = wide_ff;
      if (ctl.load) begin
         rank_x_in = '0;
         rank_y_in = '0;
         wide_in   = 1'b0;
      end else if (ctl.compare) begin
         rank_x_in = rank_x_ff + STEP_W'(less_x);
         rank_y_in = rank_y_ff + STEP_W'(less_y);
         wide_in   = wide_ff | far_x | far_y;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         own_x_ff <= shift_x;
         own_y_ff <= shift_y;
      end
      if (ctl.load) begin
         vis_x_ff <= own_left_x;
         vis_y_ff <= own_left_y;
      end else if (ctl.compare) begin
         vis_x_ff <= vis_left_x;
         vis_y_ff <= vis_left_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_x_ff <= '0;
         rank_y_ff <= '0;
         wide_ff   <= 1'b0;
      end else begin
         rank_x_ff <= rank_x_in;
         rank_y_ff <= rank_y_in;
         wide_ff   <= wide_in;
      end
   end

   assign own_x = own_x_ff;
   assign own_y = own_y_ff;
   assign vis_x = vis_x_ff;
   assign vis_y = vis_y_ff;
   assign hit_x = (rank_x_ff == MID_RANK);
   assign hit_y = (rank_y_ff == MID_RANK);
   assign wide  = wide_ff;

endmodule

// ===== rtl/core/tpq_chain.sv =====
// row of window cells joined in a ring, with the median and spread reduction
// depends on tpq_pkg and tpq_cell

module tpq_chain #(
   parameter int WINDOW_SAMPLES = tpq_pkg::WINDOW_SAMPLES,
   localparam int STEP_W        = $clog2(WINDOW_SAMPLES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tpq_pkg::cell_ctl_type  ctl,
   input  logic [STEP_W-1:0]      step,
   input  tpq_pkg::spread_type    max_spread,
   input  tpq_pkg::coord_type     sample_x,
   input  tpq_pkg::coord_type     sample_y,
   output tpq_pkg::chain_res_type res
);

   tpq_pkg::coord_type own_x [WINDOW_SAMPLES];
   tpq_pkg::coord_type own_y [WINDOW_SAMPLES];
   tpq_pkg::coord_type vis_x [WINDOW_SAMPLES];
   tpq_pkg::coord_type vis_y [WINDOW_SAMPLES];
   logic [WINDOW_SAMPLES-1:0] hit_x, hit_y, wide_v;

   for (genvar g = 0; g < WINDOW_SAMPLES; g++) begin : g_cell
      localparam int LEFT = (g + WINDOW_SAMPLES - 1) % WINDOW_SAMPLES;
      tpq_pkg::coord_type shift_x, shift_y;

      // newest sample enters cell zero, older ones move one cell up
      if (g == 0) begin : g_head
         assign shift_x = sample_x;
         assign shift_y = sample_y;
      end else begin : g_body
         assign shift_x = own_x[g-1];
         assign shift_y = own_y[g-1];
      end

      tpq_cell #(
         .WINDOW_SAMPLES (WINDOW_SAMPLES),
         .CELL_INDEX     (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .step       (step),
         .max_spread (max_spread),
         .shift_x    (shift_x),
         .shift_y    (shift_y),
         .own_left_x (own_x[LEFT]),
         .own_left_y (own_y[LEFT]),
         .vis_left_x (vis_x[LEFT]),
         .vis_left_y (vis_y[LEFT]),
         .own_x      (own_x[g]),
         .own_y      (own_y[g]),
         .vis_x      (vis_x[g]),
         .vis_y      (vis_y[g]),
         .hit_x      (hit_x[g]),
         .hit_y      (hit_y[g]),
         .wide       (wide_v[g])
      );
   end

   // ranks form a permutation, so exactly one cell hits the middle rank
   always_comb begin
      res.wide  = |wide_v;
      res.med_x = '0;
      res.med_y = '0;
      for (int i = 0; i < WINDOW_SAMPLES; i++) begin
         if (hit_x[i]) res.med_x = res.med_x | own_x[i];
         if (hit_y[i]) res.med_y = res.med_y | own_y[i];
      end
   end

endmodule

// ===== rtl/core/tpq_checker.sv =====
// port-level checks for touch_press_qualifier_unit, attached with bind
// depends on tpq_pkg

module tpq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               press_valid,
   input tpq_pkg::coord_type press_x,
   input tpq_pkg::coord_type press_y
);

   // a waiting response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // no press means zero coordinates
   a_no_press_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !press_valid |-> (press_x == '0) && (press_y == '0))
      else $error("coordinates not zero without a press");

   // one poll at a time: the request side closes right after a take
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a poll is in flight");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word survived reset");

endmodule

bind touch_press_qualifier_unit tpq_checker u_tpq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .press_valid (rsp_ch.press_valid),
   .press_x     (rsp_ch.press_x),
   .press_y     (rsp_ch.press_y)
);

// ===== tb/tpq_press_checker.sv =====
// press checker: watches the request, response and register channels of the qualifier,
// predicts each response word and compares it field by field
// depends on tpq_pkg, tpq_req_if, tpq_rsp_if and tpq_csr_if

module tpq_press_checker (
   input  logic clock,
   input  logic reset,
   tpq_req_if   req_mon,
   tpq_rsp_if   rsp_mon,
   tpq_csr_if   csr_mon,
   output int   fail_count,
   output int   pending,
   output int   press_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tpq_pkg::*;

   typedef struct packed {
      logic      press_valid;
      coord_type press_x;
      coord_type press_y;
   } press_word_type;

   // predicted copy of the press tracking and the registers
   guard_type  guard_ms;
   spread_type spread_lim;
   logic       prev_down;
   logic       press_done;
   int         fill_count;
   coord_type  win_x[WINDOW_SAMPLES];
   coord_type  win_y[WINDOW_SAMPLES];
   time_type   release_ms;

   press_word_type press_q[$];
   int errors = 0;
   int presses = 0;

   assign fail_count  = errors;
   assign press_count = presses;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s at %0t ns: got %0d, expected %0d", what, $realtime, got, want);
      errors++;
   endtask

   function automatic int window_spread(input coord_type w[WINDOW_SAMPLES]);
      int lo;
      int hi;
      lo = w[0];
      hi = w[0];
      for (int i = 1; i < WINDOW_SAMPLES; i++) begin
         if (w[i] < lo) lo = w[i];
         if (w[i] > hi) hi = w[i];
      end
      return hi - lo;
   endfunction

   // upper median of the ascending sorted window
   function automatic coord_type window_median(input coord_type w[WINDOW_SAMPLES]);
      int s[WINDOW_SAMPLES];
      int v;
      int j;
      for (int i = 0; i < WINDOW_SAMPLES; i++) begin
         v = w[i];
         j = i;
         while (j > 0 && s[j-1] > v) begin
            s[j] = s[j-1];
            j--;
         end
         s[j] = v;
      end
      return coord_type'(s[WINDOW_SAMPLES/2]);
   endfunction

   function automatic press_word_type qualify_poll(input logic down, input coord_type x,
                                                   input coord_type y, input time_type now);
      press_word_type res;
      time_type       elapsed;
      res = '0;
      if (down) begin
         if (!prev_down) begin
            fill_count = 0;
            press_done = 1'b0;
         end
         elapsed = now - release_ms;
         if (!press_done && elapsed > time_type'(guard_ms)) begin
            if (fill_count < WINDOW_SAMPLES) begin
               win_x[fill_count] = x;
               win_y[fill_count] = y;
               fill_count++;
            end
            if (fill_count == WINDOW_SAMPLES) begin
               if (window_spread(win_x) > int'(spread_lim) ||
                   window_spread(win_y) > int'(spread_lim)) begin
                  // too wide: keep the newest sample and start over
                  win_x[0]   = win_x[WINDOW_SAMPLES-1];
                  win_y[0]   = win_y[WINDOW_SAMPLES-1];
                  fill_count = 1;
               end else begin
                  res.press_valid = 1'b1;
                  res.press_x     = window_median(win_x);
                  res.press_y     = window_median(win_y);
                  press_done      = 1'b1;
               end
            end
         end
      end else begin
         if (prev_down) release_ms = now;
         fill_count = 0;
         press_done = 1'b0;
      end
      prev_down = down;
      return res;
   endfunction

   always @(posedge clock) begin
      press_word_type got;
      press_word_type want;
      if (reset) begin
         guard_ms   = GUARD_RESET;
         spread_lim = SPREAD_RESET;
         prev_down  = 1'b0;
         press_done = 1'b0;
         fill_count = 0;
         release_ms = '0;
         for (int i = 0; i < WINDOW_SAMPLES; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
         end
         press_q.delete();
      end else begin
         // response first, so a word taken at this edge is never matched against itself
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.press_valid = rsp_mon.press_valid;
            got.press_x     = rsp_mon.press_x;
            got.press_y     = rsp_mon.press_y;
            if (press_q.size() == 0) begin
               report_mismatch("unexpected response word", got.press_valid, 0);
            end else begin
               want = press_q.pop_front();
               if (got.press_valid !== want.press_valid)
                  report_mismatch("press_valid", got.press_valid, want.press_valid);
               if (got.press_x !== want.press_x)
                  report_mismatch("press_x", got.press_x, want.press_x);
               if (got.press_y !== want.press_y)
                  report_mismatch("press_y", got.press_y, want.press_y);
               if (want.press_valid) presses++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            press_q.push_back(qualify_poll(req_mon.touch_down, req_mon.pos_x,
                                           req_mon.pos_y, req_mon.now_ms));
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_RELEASE_GUARD: guard_ms   = csr_mon.data;
               CSR_MAX_SPREAD:    spread_lim = csr_mon.data[SPREAD_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= press_q.size();
   end

endmodule

// ===== tb/touch_press_qualifier_unit_tb.sv =====
// testbench top of the touch press qualifier: clock, reset, poll stimulus, idling and verdict
// depends on tpq_pkg, the three channel interfaces, tpq_press_checker and the block itself

module touch_press_qualifier_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpq_pkg::*;

   // cycles without any accepted word before the run is declared hung
   localparam int STALL_LIMIT     = 4000;
   // long receiver hold-off so the block fills up and back-pressures its input
   localparam int HOLD_OFF_CYCLES = 300;
   // drain wait, longer than a completing word takes from accept to hand-off
   localparam int DRAIN_CYCLES    = WINDOW_SAMPLES + 6;
   localparam int PHASE_POLLS     = 250;
   localparam int NUM_PHASES      = 5;

   // register indexes past the end of the list, writes there are dropped
   localparam csr_idx_type CSR_SPARE_LO = 2'd2;
   localparam csr_idx_type CSR_SPARE_HI = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpq_req_if req_ch ();
   tpq_rsp_if rsp_ch ();
   tpq_csr_if csr_ch ();

   int fail_count;
   int pending;
   int press_count;

   // idling knobs, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;

   int         polls_sent = 0;
   time_type   poll_ms    = '0;
   guard_type  guard_now  = GUARD_RESET;
   spread_type spread_now = SPREAD_RESET;

   touch_press_qualifier_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tpq_press_checker press_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .fail_count  (fail_count),
      .pending     (pending),
      .press_count (press_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when one is requested
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog: ends the run when no word moves on any channel for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   // offer one poll word, called and returning at a falling edge; valid stays high
   task automatic send_poll(input logic down, input coord_type x, input coord_type y,
                            input time_type now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.touch_down <= down;
      req_ch.pos_x      <= x;
      req_ch.pos_y      <= y;
      req_ch.now_ms     <= now;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      polls_sent++;
   endtask

   // one register write word; valid is left high for back-to-back writes
   task automatic write_reg(input csr_idx_type idx, input csr_dat_type val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      if (idx == CSR_RELEASE_GUARD) guard_now = val;
      else if (idx == CSR_MAX_SPREAD) spread_now = val[SPREAD_W-1:0];
   endtask

   // wait for the block to go idle, then program both registers and a spare index
   task automatic drain_and_program(input csr_dat_type guard_val, input csr_dat_type spread_val);
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_reg(CSR_RELEASE_GUARD, guard_val);
      write_reg(CSR_MAX_SPREAD, spread_val);
      write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, csr_dat_type'($urandom));
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // a well-formed press: release, wait out (or nearly) the guard, then a run of
   // down polls jittering around one spot
   task automatic press_session();
      int n_rel;
      int n_down;
      int jit;
      int bx;
      int by;
      n_rel = $urandom_range(1, 2);
      repeat (n_rel) begin
         send_poll(1'b0, coord_type'($urandom), coord_type'($urandom), poll_ms);
         poll_ms += $urandom_range(1, 10);
      end
      // lands a little before or after the guard boundary
      poll_ms += guard_now + $urandom_range(40) - 10;
      jit = spread_now / 2;
      if ($urandom_range(3) == 0) jit += $urandom_range(1, 40);
      if (jit > 1000) jit = 1000;
      bx = int'($urandom_range(4095 - 2 * jit)) - 2048 + jit;
      by = int'($urandom_range(4095 - 2 * jit)) - 2048 + jit;
      n_down = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      repeat (n_down) begin
         send_poll(1'b1, coord_type'(bx + int'($urandom_range(2 * jit)) - jit),
                   coord_type'(by + int'($urandom_range(2 * jit)) - jit), poll_ms);
         poll_ms += $urandom_range(1, 15);
      end
   endtask

   // short burst of arbitrary polls, sometimes with a fully random timestamp
   task automatic noise_burst();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         if ($urandom_range(1)) poll_ms += $urandom_range(100);
         else poll_ms = $urandom;
         send_poll(1'($urandom_range(1)), coord_type'($urandom), coord_type'($urandom), poll_ms);
      end
   endtask

   task automatic run_phase(input int target);
      while (polls_sent < target) begin
         if ($urandom_range(9) < 8) press_session();
         else noise_burst();
      end
   endtask

   initial begin
      int          dx[WINDOW_SAMPLES];
      int          dy[WINDOW_SAMPLES];
      csr_dat_type guard_plan[NUM_PHASES];
      csr_dat_type spread_plan[NUM_PHASES];
      int          send_plan[NUM_PHASES];
      int          recv_plan[NUM_PHASES];

      req_ch.valid      = 1'b0;
      req_ch.touch_down = 1'b0;
      req_ch.pos_x      = '0;
      req_ch.pos_y      = '0;
      req_ch.now_ms     = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_RELEASE_GUARD;
      csr_ch.data       = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, reset register values (guard 70, spread 10) ----
      // release with no earlier down: tracking cleared, release time stays 0
      send_poll(1'b0, 12'sd0, 12'sd0, 32'd100);
      // inside the guard, then exactly on it: neither counts
      send_poll(1'b1, 12'sd0, 12'sd0, 32'd50);
      send_poll(1'b1, 12'sd0, 12'sd0, 32'd70);
      // stable window at the top x and bottom y corner, spread exactly at the limit
      dx = '{2047, 2037, 2045, 2040, 2047};
      dy = '{-2048, -2038, -2040, -2045, -2048};
      for (int i = 0; i < WINDOW_SAMPLES; i++)
         send_poll(1'b1, coord_type'(dx[i]), coord_type'(dy[i]), 32'd71 + i);
      // press already handled, no second report
      send_poll(1'b1, 12'sd0, 12'sd0, 32'd80);
      // release, then a down inside the new guard
      send_poll(1'b0, -12'sd1, -12'sd1, 32'd1000);
      send_poll(1'b1, 12'sd0, 12'sd0, 32'd1050);
      // y spread one over the limit: window restarts from the newest sample
      dy = '{-5, 6, 0, 0, 0};
      for (int i = 0; i < WINDOW_SAMPLES; i++)
         send_poll(1'b1, 12'sd0, coord_type'(dy[i]), 32'd1100 + i);
      dy = '{0, 1, 2, 0, 0};
      for (int i = 0; i < WINDOW_SAMPLES - 1; i++)
         send_poll(1'b1, 12'sd0, coord_type'(dy[i]), 32'd1200 + i);
      // release just before the 32-bit wrap, press just after it
      send_poll(1'b1, 12'sd0, 12'sd0, 32'hFFFF_FFE0);
      send_poll(1'b0, 12'sd0, 12'sd0, 32'hFFFF_FFF0);
      for (int i = 0; i < WINDOW_SAMPLES; i++)
         send_poll(1'b1, -12'sd1, 12'sd1, 32'h50 + i);
      poll_ms = 32'h100;

      // random presses with the reset register values, no idling
      run_phase(polls_sent + PHASE_POLLS);

      // ---- register settings: extremes first, then middling and random ----
      guard_plan  = '{16'd0, 16'hFFFF, 16'd30, 16'd0, 16'd5};
      spread_plan = '{16'd0, 16'hFFFF, 16'd25, 16'd0, 16'hF003};
      guard_plan[3]  = csr_dat_type'($urandom_range(200));
      spread_plan[3] = csr_dat_type'($urandom_range(200));
      send_plan   = '{0, 50, 0, 27, 50};
      recv_plan   = '{0, 0, 50, 27, 0};

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_and_program(guard_plan[p], spread_plan[p]);
         send_idle_pct  = send_plan[p];
         recv_stall_pct = recv_plan[p];
         if (p == 0) begin
            // zero guard: a down in the same millisecond as the release still waits
            send_poll(1'b1, 12'sd0, 12'sd0, poll_ms);
            send_poll(1'b0, 12'sd0, 12'sd0, poll_ms);
            send_poll(1'b1, 12'sd0, 12'sd0, poll_ms);
         end
         if (p == 2) hold_request = HOLD_OFF_CYCLES;
         run_phase(polls_sent + PHASE_POLLS);
      end

      // ---- wind down ----
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d touch polls over %0d register settings and four idling patterns",
               polls_sent, NUM_PHASES + 1);
      $display("%0d qualified presses reported, %0d mismatches", press_count, fail_count);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tpq_pkg.sv
rtl/core/tpq_req_if.sv
rtl/core/tpq_rsp_if.sv
rtl/core/tpq_csr_if.sv
rtl/core/tpq_cell.sv
rtl/core/tpq_chain.sv
rtl/core/touch_press_qualifier_unit.sv
rtl/core/tpq_checker.sv
tb/tpq_press_checker.sv
tb/touch_press_qualifier_unit_tb.sv
